// ----- rtl/mlsr_pkg.sv -----
package mlsr_pkg;

	localparam int W_VAL  = 32;             // Q16.16 value width
	localparam int W_DIFF = W_VAL + 1;      // cell difference
	localparam int W_WGT  = 16;             // Q1.14 weight
	localparam int W_COEF = W_WGT + 1;      // 1 +/- w in Q1.14
	localparam int W_PROD = W_COEF + W_DIFF;
	localparam int W_NUM  = W_PROD + 1;
	localparam int W_DLT  = 36;             // delta, Q16.16 with headroom
	localparam int W_XI   = 17;             // xi, unsigned Q1.16, 0..65536
	localparam int W_XD   = W_XI + 1 + W_DLT;
	localparam int W_HALF = 35;
	localparam int W_DEN  = W_VAL + 1;      // divisor: 2|dp| or |dm|+|dp|
	localparam int W_FACE = W_VAL + 4;

	localparam int DLT_SHIFT = 15;
	localparam int XI_SHIFT  = 17;
	localparam int DIV_STEPS = W_XI;
	// s1, s2, divider setup + steps, multiply, half slope
	localparam int NST       = 2 + DIV_STEPS + 1 + 2;
	localparam int ST_DIV0   = 2;
	localparam int ST_MUL    = ST_DIV0 + DIV_STEPS + 1;
	localparam int ST_HALF   = ST_MUL + 1;

	localparam logic signed [W_COEF-1:0] Q14_ONE = W_COEF'(16384);
	localparam logic [W_XI-1:0]          XI_ONE  = W_XI'(65536);

	function automatic logic [W_VAL-1:0] sat32(input logic signed [W_FACE-1:0] v);
		logic [W_FACE-W_VAL:0] top;
		top = v[W_FACE-1:W_VAL-1];
		if (top == '0 || top == '1)
			return v[W_VAL-1:0];
		else if (v[W_FACE-1])
			return {1'b1, {(W_VAL-1){1'b0}}};
		else
			return {1'b0, {(W_VAL-1){1'b1}}};
	endfunction

endpackage

// ----- rtl/minbee_limited_slope_reconstruction_top.sv -----
// Minbee slope-limited face reconstruction, one variable per item.
// An item passes stage 1, stage 2, the divider setup and steps, multiply and half slope, then the output register.
// Throughput: one item per cycle while s_tready is high; the limiter ratio uses a 17-stage restoring
// divider, one quotient bit per stage, so nothing iterates.
// An output register plus one skid entry decouple the sides; s_tready drops only
// while the skid entry is full. arst_n clears all valid bits and slope_weight.
module minbee_limited_slope_reconstruction_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,    // slope_weight
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,      // value_left_cell, value_centre_cell, value_right_cell
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata       // face_value_left, face_value_right
);
	import mlsr_pkg::*;

	logic signed [W_WGT-1:0] weight_q;
	logic [NST-1:0]          vld;
	logic                    adv;

	// stage 1: differences
	logic signed [W_DIFF-1:0] dm_s1, dp_s1;
	logic [W_VAL-1:0]         uc_s1;

	// stage 2: weighted products, magnitudes, sign class
	logic signed [W_PROD-1:0] pm_s2, pp_s2;
	logic [W_VAL-1:0]         am_s2, ap_s2;
	logic                     zero_s2;
	logic [W_VAL-1:0]         uc_s2;

	// divider stages, index 0 is the setup stage
	logic [W_DEN-1:0]         dv_rem_s   [DIV_STEPS+1];
	logic [W_DEN-1:0]         dv_den_s   [DIV_STEPS+1];
	logic [W_XI-1:0]          dv_q_s     [DIV_STEPS+1];
	logic signed [W_DLT-1:0]  dv_delta_s [DIV_STEPS+1];
	logic [W_VAL-1:0]         dv_uc_s    [DIV_STEPS+1];

	logic signed [W_XD-1:0]   prod_s21;
	logic [W_VAL-1:0]         uc_s21;
	logic signed [W_HALF-1:0] half_s22;
	logic [W_VAL-1:0]         uc_s22;

	logic                     out_vld_q, skid_vld_q;
	logic [2*W_VAL-1:0]       out_data_q, skid_data_q, face_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[NST-2:0], s_tvalid};
		end
	end

	// stage 1
	logic signed [W_DIFF-1:0] ul_c, uc_c, ur_c;
	assign ul_c = $signed({s_tdata[31], s_tdata[31:0]});
	assign uc_c = $signed({s_tdata[63], s_tdata[63:32]});
	assign ur_c = $signed({s_tdata[95], s_tdata[95:64]});

	always_ff @(posedge clk) begin
		if (adv) begin
			dm_s1 <= uc_c - ul_c;
			dp_s1 <= ur_c - uc_c;
			uc_s1 <= s_tdata[63:32];
		end
	end

	// stage 2
	logic signed [W_COEF-1:0] coef_m, coef_p;
	logic [W_DIFF-1:0]        am_c, ap_c;
	assign coef_m = Q14_ONE + $signed({weight_q[W_WGT-1], weight_q});
	assign coef_p = Q14_ONE - $signed({weight_q[W_WGT-1], weight_q});
	assign am_c   = dm_s1[W_DIFF-1] ? W_DIFF'(-dm_s1) : W_DIFF'(dm_s1);
	assign ap_c   = dp_s1[W_DIFF-1] ? W_DIFF'(-dp_s1) : W_DIFF'(dp_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			pm_s2   <= coef_m * dm_s1;
			pp_s2   <= coef_p * dp_s1;
			am_s2   <= am_c[W_VAL-1:0];
			ap_s2   <= ap_c[W_VAL-1:0];
			// limiter is zero for r <= 0 or a flat forward side
			zero_s2 <= (dm_s1 == '0) || (dp_s1 == '0) || (dm_s1[W_DIFF-1] != dp_s1[W_DIFF-1]);
			uc_s2   <= uc_s1;
		end
	end

	// stage 3: delta and divider setup; xi = floor(x * 2^17 / den)
	logic signed [W_NUM-1:0] num_c;
	logic                    le_c;
	logic [W_DEN-1:0]        den_c, x_c;
	assign num_c = pm_s2 + pp_s2;
	assign le_c  = am_s2 <= ap_s2;

	always_comb begin
		if (zero_s2) begin
			x_c   = '0;
			den_c = W_DEN'(1);
		end else if (le_c) begin
			x_c   = {1'b0, am_s2};
			den_c = {ap_s2, 1'b0};
		end else begin
			x_c   = {1'b0, ap_s2};
			den_c = {1'b0, am_s2} + {1'b0, ap_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s[0]   <= x_c;
			dv_den_s[0]   <= den_c;
			dv_q_s[0]     <= '0;
			// truncate toward zero
			dv_delta_s[0] <= W_DLT'(num_c >>> DLT_SHIFT)
				+ W_DLT'(num_c[W_NUM-1] && (num_c[DLT_SHIFT-1:0] != '0));
			dv_uc_s[0]    <= uc_s2;
		end
	end

	// restoring divider, one quotient bit per stage; rem < den throughout
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [W_DEN:0] r2, diff;
		logic           ge;
		assign r2   = {dv_rem_s[k-1], 1'b0};
		assign diff = r2 - {1'b0, dv_den_s[k-1]};
		assign ge   = r2 >= {1'b0, dv_den_s[k-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[k]   <= ge ? diff[W_DEN-1:0] : r2[W_DEN-1:0];
				dv_den_s[k]   <= dv_den_s[k-1];
				dv_q_s[k]     <= {dv_q_s[k-1][W_XI-2:0], ge};
				dv_delta_s[k] <= dv_delta_s[k-1];
				dv_uc_s[k]    <= dv_uc_s[k-1];
			end
		end
	end

	// xi * delta
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s21 <= $signed({1'b0, dv_q_s[DIV_STEPS]}) * dv_delta_s[DIV_STEPS];
			uc_s21   <= dv_uc_s[DIV_STEPS];
		end
	end

	// half slope, truncated toward zero
	always_ff @(posedge clk) begin
		if (adv) begin
			half_s22 <= W_HALF'(prod_s21 >>> XI_SHIFT)
				+ W_HALF'(prod_s21[W_XD-1] && (prod_s21[XI_SHIFT-1:0] != '0));
			uc_s22   <= uc_s21;
		end
	end

	logic signed [W_FACE-1:0] uc_x, half_x;
	assign uc_x   = $signed({{(W_FACE-W_VAL){uc_s22[W_VAL-1]}}, uc_s22});
	assign half_x = $signed({{(W_FACE-W_HALF){half_s22[W_HALF-1]}}, half_s22});
	assign face_c = {sat32(uc_x + half_x), sat32(uc_x - half_x)};

	// output register with one skid entry
	logic push;
	assign push = adv && vld[ST_HALF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_data_q <= skid_vld_q ? skid_data_q : face_c;
		end else if (push) begin
			skid_data_q <= face_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTH
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry full while output register empty");

	a_skid_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready && push) |=> skid_vld_q)
		else $error("item from pipeline dropped while output stalled");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld[ST_DIV0] |-> (dv_den_s[0] != '0) && (dv_rem_s[0] < dv_den_s[0]))
		else $error("divider setup out of range");

	a_xi_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[ST_MUL-1] |-> (dv_q_s[DIV_STEPS] <= XI_ONE)
			&& (dv_rem_s[DIV_STEPS] < dv_den_s[DIV_STEPS]))
		else $error("limiter value above one");
`endif

endmodule
